[hw/rtl/cati_pkg.sv]
// Shared constants, operation codes and control/status types of the task issuer.
package cati_pkg;

	localparam int DEPTH   = 16;
	localparam int SLOT_W  = 4;
	localparam int CNT_W   = 5;
	localparam int KEY_W   = 32;
	localparam int LIMIT_W = 5;
	localparam int DATA_W  = 32;

	localparam logic [LIMIT_W-1:0] RESET_LIMIT = 5'd10;

	localparam logic [1:0] OP_ADD      = 2'd0;
	localparam logic [1:0] OP_COMPLETE = 2'd1;
	localparam logic [1:0] OP_POLL     = 2'd2;
	localparam logic [1:0] OP_CLEAR    = 2'd3;

	typedef struct packed {
		logic accept;
		logic step;
		logic finish;
	} cati_cmd_t;

	typedef struct packed {
		logic direct;
		logic scan_end;
		logic out_free;
	} cati_sts_t;

endpackage

[hw/rtl/cati_ctrl.sv]
// Controller state machine that sequences accept, table scan and result load.
module cati_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cati_pkg::cati_sts_t sts,
	output cati_pkg::cati_cmd_t cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = sts.direct ? S_FINISH : S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.step = 1'b1;
				if (sts.scan_end) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hw/rtl/cati_dp.sv]
// Datapath holding the task table, the scan registers and the result register.
module cati_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cati_pkg::cati_cmd_t           cmd,
	output cati_pkg::cati_sts_t           sts,
	input  logic [cati_pkg::LIMIT_W-1:0]  max_running,
	input  logic [1:0]                    operation,
	input  logic [cati_pkg::KEY_W-1:0]    task_key,
	input  logic [cati_pkg::SLOT_W-1:0]   task_slot,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          issued,
	output logic [cati_pkg::SLOT_W-1:0]   issued_slot,
	output logic                          throttled,
	output logic                          all_done,
	output logic                          notify,
	output logic                          rejected
);

	logic [cati_pkg::DEPTH-1:0]  valid_q;
	logic [cati_pkg::DEPTH-1:0]  started_q;
	logic [cati_pkg::DEPTH-1:0]  completed_q;
	logic [cati_pkg::KEY_W-1:0]  key_q [cati_pkg::DEPTH];
	logic [cati_pkg::CNT_W-1:0]  count_q;

	logic [1:0]                  op_q;
	logic                        scanned_q;
	logic                        rej_q;
	logic [cati_pkg::LIMIT_W-1:0] limit_q;
	logic [cati_pkg::SLOT_W-1:0] idx_q;
	logic [cati_pkg::CNT_W-1:0]  running_q;
	logic                        found_q;

	logic                        out_valid_q;
	logic                        out_issued_q;
	logic [cati_pkg::SLOT_W-1:0] out_slot_q;
	logic                        out_thr_q;
	logic                        out_done_q;
	logic                        out_note_q;
	logic                        out_rej_q;

	logic                        full;
	logic [cati_pkg::SLOT_W-1:0] wr_slot;
	logic [cati_pkg::DEPTH-1:0]  run_vec;
	logic [cati_pkg::DEPTH-1:0]  match_vec;
	logic [cati_pkg::KEY_W-1:0]  cand_key;
	logic                        busy;
	logic                        found_now;
	logic                        run_now;
	logic                        thr_lim;
	logic                        fin_iss;
	logic                        fin_thr;
	logic                        fin_idle;

	assign full     = (count_q == cati_pkg::CNT_W'(cati_pkg::DEPTH));
	assign wr_slot  = count_q[cati_pkg::SLOT_W-1:0];
	assign run_vec  = valid_q & started_q & ~completed_q;
	assign cand_key = key_q[idx_q];

	always_comb begin
		for (int j = 0; j < cati_pkg::DEPTH; j++) begin
			match_vec[j] = (key_q[j] == cand_key);
		end
	end

	assign busy      = |(run_vec & match_vec);
	assign found_now = valid_q[idx_q] & ~started_q[idx_q] & ~busy;
	assign run_now   = run_vec[idx_q];

	assign sts.direct   = (operation == cati_pkg::OP_CLEAR)
	                   || ((operation == cati_pkg::OP_ADD) && full);
	assign sts.scan_end = found_now || (idx_q == cati_pkg::SLOT_W'(cati_pkg::DEPTH - 1));
	assign sts.out_free = !out_valid_q || out_ready;

	assign thr_lim  = (limit_q != '0) && (running_q >= cati_pkg::CNT_W'(limit_q));
	assign fin_iss  = scanned_q && !thr_lim && found_q;
	assign fin_thr  = scanned_q && (thr_lim || (!found_q && (running_q != '0)));
	assign fin_idle = scanned_q && !fin_iss && !fin_thr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			started_q   <= '0;
			completed_q <= '0;
			count_q     <= '0;
			op_q        <= cati_pkg::OP_ADD;
			scanned_q   <= 1'b0;
			rej_q       <= 1'b0;
			limit_q     <= '0;
			idx_q       <= '0;
			running_q   <= '0;
			found_q     <= 1'b0;
		end else begin
			if (cmd.accept) begin
				op_q      <= operation;
				scanned_q <= !sts.direct;
				rej_q     <= (operation == cati_pkg::OP_ADD) && full;
				limit_q   <= (operation == cati_pkg::OP_COMPLETE) ? '0 : max_running;
				idx_q     <= '0;
				running_q <= '0;
				found_q   <= 1'b0;
				case (operation)
					cati_pkg::OP_ADD: begin
						if (!full) begin
							valid_q[wr_slot]     <= 1'b1;
							started_q[wr_slot]   <= 1'b0;
							completed_q[wr_slot] <= 1'b0;
							count_q              <= count_q + 1'b1;
						end
					end
					cati_pkg::OP_COMPLETE: begin
						if (valid_q[task_slot] && started_q[task_slot]) begin
							completed_q[task_slot] <= 1'b1;
						end
					end
					cati_pkg::OP_CLEAR: begin
						valid_q     <= '0;
						started_q   <= '0;
						completed_q <= '0;
						count_q     <= '0;
					end
					default: begin
					end
				endcase
			end else if (cmd.step) begin
				if (found_now) begin
					found_q <= 1'b1;
				end else begin
					if (run_now) begin
						running_q <= running_q + 1'b1;
					end
					if (!sts.scan_end) begin
						idx_q <= idx_q + 1'b1;
					end
				end
			end else if (cmd.finish && fin_iss) begin
				started_q[idx_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && (operation == cati_pkg::OP_ADD) && !full) begin
			key_q[wr_slot] <= task_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_issued_q <= fin_iss;
			out_slot_q   <= fin_iss ? idx_q : '0;
			out_thr_q    <= fin_thr;
			out_done_q   <= fin_idle && (op_q != cati_pkg::OP_COMPLETE);
			out_note_q   <= fin_idle && (op_q == cati_pkg::OP_COMPLETE);
			out_rej_q    <= rej_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign issued      = out_issued_q;
	assign issued_slot = out_slot_q;
	assign throttled   = out_thr_q;
	assign all_done    = out_done_q;
	assign notify      = out_note_q;
	assign rejected    = out_rej_q;

endmodule

[hw/rtl/conflict_aware_task_issuer_unit.sv]
// Top level of the conflict-aware task issuer: register port, controller and datapath.
// An item with a scan steps through the table one entry per cycle up to the pick or the last
// entry, then loads its result word once the result register is free; a clear or an add to a
// full table skips the scan. A new item is accepted only after the last one's word is loaded.
// Reset clears the table, the fill count and the result valid flag, and sets max_running to 10.
module conflict_aware_task_issuer_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [2:0]                          paddr,
	input  logic [cati_pkg::DATA_W-1:0]         pwdata,
	output logic [cati_pkg::DATA_W-1:0]         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          operation,
	input  logic [cati_pkg::KEY_W-1:0]          task_key,
	input  logic [cati_pkg::SLOT_W-1:0]         task_slot,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                issued,
	output logic [cati_pkg::SLOT_W-1:0]         issued_slot,
	output logic                                throttled,
	output logic                                all_done,
	output logic                                notify,
	output logic                                rejected
);

	logic [cati_pkg::LIMIT_W-1:0] max_running_q;
	cati_pkg::cati_cmd_t          cmd;
	cati_pkg::cati_sts_t          sts;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? '0
	              : {{(cati_pkg::DATA_W - cati_pkg::LIMIT_W){1'b0}}, max_running_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_running_q <= cati_pkg::RESET_LIMIT;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			max_running_q <= pwdata[cati_pkg::LIMIT_W-1:0];
		end
	end

	cati_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cati_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.max_running (max_running_q),
		.operation   (operation),
		.task_key    (task_key),
		.task_slot   (task_slot),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.issued      (issued),
		.issued_slot (issued_slot),
		.throttled   (throttled),
		.all_done    (all_done),
		.notify      (notify),
		.rejected    (rejected)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Input accepted again in the cycle after an accept.");

	a_issue_not_throttled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(issued && throttled))
		else $error("A word is both issued and throttled.");

	a_reject_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> !issued && !throttled && !all_done && !notify)
		else $error("A rejected add carries other result flags.");

	a_done_or_notify: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(all_done && notify))
		else $error("A word reports both done and notify.");

endmodule

[dv/tb_conflict_aware_task_issuer_unit.sv]
// Self-checking testbench for the task issuer: directed table, random traffic, limit sweeps.
module tb_conflict_aware_task_issuer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] ADDR_MAX_RUNNING = 3'd0;
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEMS_PER_PHASE = 300;
	localparam int HOLD_CYCLES = 500;

	typedef struct packed {
		logic                        issued;
		logic [cati_pkg::SLOT_W-1:0] slot;
		logic                        throttled;
		logic                        all_done;
		logic                        notify;
		logic                        rejected;
	} result_t;

	typedef struct packed {
		logic [1:0]                  op;
		logic [cati_pkg::KEY_W-1:0]  key;
		logic [cati_pkg::SLOT_W-1:0] slot;
		logic                        typed;
		result_t                     want;
	} dir_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [2:0]                    paddr;
	logic [cati_pkg::DATA_W-1:0]   pwdata;
	logic [cati_pkg::DATA_W-1:0]   prdata;
	logic                          pready;
	logic                          in_valid;
	logic                          in_ready;
	logic [1:0]                    operation;
	logic [cati_pkg::KEY_W-1:0]    task_key;
	logic [cati_pkg::SLOT_W-1:0]   task_slot;
	logic                          out_valid;
	logic                          out_ready;
	logic                          issued;
	logic [cati_pkg::SLOT_W-1:0]   issued_slot;
	logic                          throttled;
	logic                          all_done;
	logic                          notify;
	logic                          rejected;

	conflict_aware_task_issuer_unit dut (.*);

	// Shadow copy of the task table and the running limit.
	logic                       tab_valid [cati_pkg::DEPTH];
	logic                       tab_started [cati_pkg::DEPTH];
	logic                       tab_completed [cati_pkg::DEPTH];
	logic [cati_pkg::KEY_W-1:0] tab_key [cati_pkg::DEPTH];
	int                         tab_count;
	int unsigned                run_limit;

	result_t pending_words [$];
	int errors;
	int cycle_cnt;
	int tx_idle_pct;
	int rx_idle_pct;
	bit hold_rx;
	logic [cati_pkg::KEY_W-1:0] key_pool [4];
	dir_row_t dir_tab [0:16];
	int unsigned phase_limit [6];

	function automatic bit key_in_use(input int self, input logic [cati_pkg::KEY_W-1:0] k);
		for (int j = 0; j < tab_count; j++) begin
			if (j != self && tab_valid[j] && tab_started[j] && !tab_completed[j] &&
				tab_key[j] == k)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic result_t pick_and_start(input int unsigned lim);
		result_t r;
		int unsigned running;
		bit found;
		int pick;
		r = '0;
		running = 0;
		found = 1'b0;
		pick = 0;
		for (int i = 0; i < tab_count && !found; i++) begin
			if (!tab_valid[i])
				continue;
			if (tab_started[i]) begin
				if (!tab_completed[i])
					running++;
				continue;
			end
			if (key_in_use(i, tab_key[i]))
				continue;
			found = 1'b1;
			pick = i;
		end
		if (lim != 0 && running >= lim) begin
			r.throttled = 1'b1;
		end else if (!found) begin
			r.throttled = (running != 0);
		end else begin
			tab_started[pick] = 1'b1;
			r.issued = 1'b1;
			r.slot = pick[cati_pkg::SLOT_W-1:0];
		end
		return r;
	endfunction

	function automatic void clear_table();
		for (int i = 0; i < cati_pkg::DEPTH; i++) begin
			tab_valid[i] = 1'b0;
			tab_started[i] = 1'b0;
			tab_completed[i] = 1'b0;
		end
		tab_count = 0;
	endfunction

	function automatic result_t issuer_outcome(input logic [1:0] op,
			input logic [cati_pkg::KEY_W-1:0] k, input logic [cati_pkg::SLOT_W-1:0] s);
		result_t r;
		r = '0;
		case (op)
			cati_pkg::OP_ADD: begin
				if (tab_count >= cati_pkg::DEPTH) begin
					r.rejected = 1'b1;
				end else begin
					tab_valid[tab_count] = 1'b1;
					tab_started[tab_count] = 1'b0;
					tab_completed[tab_count] = 1'b0;
					tab_key[tab_count] = k;
					tab_count++;
					r = pick_and_start(run_limit);
					r.all_done = !r.issued && !r.throttled;
				end
			end
			cati_pkg::OP_COMPLETE: begin
				if (tab_valid[s] && tab_started[s])
					tab_completed[s] = 1'b1;
				r = pick_and_start(0);
				r.notify = !r.issued && !r.throttled;
			end
			cati_pkg::OP_POLL: begin
				r = pick_and_start(run_limit);
				r.all_done = !r.issued && !r.throttled;
			end
			default: begin
				clear_table();
			end
		endcase
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("tb_conflict_aware_task_issuer_unit: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %0h", $time,
					{issued, issued_slot, throttled, all_done, notify, rejected});
				errors++;
			end else begin
				want = pending_words.pop_front();
				check_field("issued", want.issued, issued);
				check_field("issued_slot", want.slot, issued_slot);
				check_field("throttled", want.throttled, throttled);
				check_field("all_done", want.all_done, all_done);
				check_field("notify", want.notify, notify);
				check_field("rejected", want.rejected, rejected);
			end
		end
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rx) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_rx = 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	task automatic offer(input logic [1:0] op, input logic [cati_pkg::KEY_W-1:0] k,
			input logic [cati_pkg::SLOT_W-1:0] s, input logic typed,
			input result_t typed_want);
		result_t r;
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		task_key <= k;
		task_slot <= s;
		do @(posedge clk); while (!in_ready);
		r = issuer_outcome(op, k, s);
		pending_words.push_back(typed ? typed_want : r);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_xfer(input bit wr, input logic [cati_pkg::DATA_W-1:0] wdata,
			output logic [cati_pkg::DATA_W-1:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ADDR_MAX_RUNNING;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_limit(input int unsigned lim);
		logic [cati_pkg::DATA_W-1:0] rd;
		apb_xfer(1'b1, cati_pkg::DATA_W'(lim), rd);
		run_limit = lim;
		apb_xfer(1'b0, '0, rd);
		check_field("max_running", lim, rd[cati_pkg::LIMIT_W-1:0]);
	endtask

	task automatic refresh_pool();
		for (int i = 0; i < 4; i++)
			key_pool[i] = $urandom;
	endtask

	task automatic random_items(input int n, input bit pressure);
		int sel;
		int live [$];
		logic [1:0] op;
		logic [cati_pkg::KEY_W-1:0] k;
		logic [cati_pkg::SLOT_W-1:0] s;
		for (int n_done = 0; n_done < n; n_done++) begin
			if (pressure && n_done == n / 3)
				hold_rx = 1'b1;
			if (pressure && n_done == 2 * n / 3)
				wait_drained();
			sel = $urandom_range(0, 99);
			k = $urandom;
			s = cati_pkg::SLOT_W'($urandom_range(0, cati_pkg::DEPTH - 1));
			if (sel < 50) begin
				op = cati_pkg::OP_ADD;
				if ($urandom_range(0, 99) < 65)
					k = key_pool[$urandom_range(0, 3)];
			end else if (sel < 78) begin
				op = cati_pkg::OP_COMPLETE;
				live.delete();
				for (int i = 0; i < tab_count; i++) begin
					if (tab_valid[i] && tab_started[i] && !tab_completed[i])
						live.push_back(i);
				end
				if (live.size() != 0 && $urandom_range(0, 99) < 75)
					s = cati_pkg::SLOT_W'(live[$urandom_range(0, live.size() - 1)]);
			end else if (sel < 97) begin
				op = cati_pkg::OP_POLL;
			end else begin
				op = cati_pkg::OP_CLEAR;
				refresh_pool();
			end
			offer(op, k, s, 1'b0, '0);
		end
	endtask

	initial begin
		logic [cati_pkg::DATA_W-1:0] rd;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		operation = cati_pkg::OP_POLL;
		task_key = '0;
		task_slot = '0;
		errors = 0;
		cycle_cnt = 0;
		hold_rx = 1'b0;
		tx_idle_pct = 26;
		rx_idle_pct = 87;
		clear_table();
		run_limit = cati_pkg::RESET_LIMIT;
		refresh_pool();
		phase_limit = '{1, 16, 0, 2, 7, 16};

		// Fields: op, key, slot, typed, {issued, slot, throttled, all_done, notify, rejected}.
		dir_tab = '{
			'{cati_pkg::OP_POLL,     32'h0,        4'd0,  1'b1,
				'{1'b0, 4'd0, 1'b0, 1'b1, 1'b0, 1'b0}},
			'{cati_pkg::OP_COMPLETE, 32'h0,        4'd15, 1'b1,
				'{1'b0, 4'd0, 1'b0, 1'b0, 1'b1, 1'b0}},
			'{cati_pkg::OP_CLEAR,    32'h0,        4'd0,  1'b1,
				'{1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
			'{cati_pkg::OP_ADD,      32'h0,        4'd0,  1'b1,
				'{1'b1, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
			'{cati_pkg::OP_ADD,      32'h0,        4'd0,  1'b1,
				'{1'b0, 4'd0, 1'b1, 1'b0, 1'b0, 1'b0}},
			'{cati_pkg::OP_ADD,      32'hFFFFFFFF, 4'd0,  1'b1,
				'{1'b1, 4'd2, 1'b0, 1'b0, 1'b0, 1'b0}},
			'{cati_pkg::OP_COMPLETE, 32'h0,        4'd0,  1'b1,
				'{1'b1, 4'd1, 1'b0, 1'b0, 1'b0, 1'b0}},
			'{cati_pkg::OP_COMPLETE, 32'h0,        4'd0,  1'b0, '0},
			'{cati_pkg::OP_COMPLETE, 32'h0,        4'd9,  1'b0, '0},
			'{cati_pkg::OP_POLL,     32'h0,        4'd0,  1'b0, '0},
			'{cati_pkg::OP_COMPLETE, 32'h0,        4'd1,  1'b0, '0},
			'{cati_pkg::OP_COMPLETE, 32'h0,        4'd2,  1'b1,
				'{1'b0, 4'd0, 1'b0, 1'b0, 1'b1, 1'b0}},
			'{cati_pkg::OP_ADD,      32'h55555555, 4'd0,  1'b0, '0},
			'{cati_pkg::OP_ADD,      32'hAAAAAAAA, 4'd0,  1'b0, '0},
			'{cati_pkg::OP_COMPLETE, 32'h0,        4'd15, 1'b0, '0},
			'{cati_pkg::OP_POLL,     32'h0,        4'd0,  1'b0, '0},
			'{cati_pkg::OP_CLEAR,    32'h0,        4'd0,  1'b1,
				'{1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0}}
		};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		apb_xfer(1'b0, '0, rd);
		check_field("max_running", cati_pkg::RESET_LIMIT, rd[cati_pkg::LIMIT_W-1:0]);

		for (int r = 0; r <= 16; r++)
			offer(dir_tab[r].op, dir_tab[r].key, dir_tab[r].slot, dir_tab[r].typed,
				dir_tab[r].want);
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph < 2) begin
				tx_idle_pct = 26;
				rx_idle_pct = 87;
			end else if (ph < 4) begin
				tx_idle_pct = 87;
				rx_idle_pct = 26;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			set_limit(phase_limit[ph]);
			random_items(ITEMS_PER_PHASE, ph == 1);
			wait_drained();
		end

		repeat (40) @(posedge clk);
		if (pending_words.size() != 0) begin
			$display("%0t: words still expected, expected 0, actual %0d", $time,
				pending_words.size());
			errors++;
		end
		if (errors == 0)
			$display("tb_conflict_aware_task_issuer_unit: done, clean");
		else
			$display("tb_conflict_aware_task_issuer_unit: done, errors");
		$finish;
	end

endmodule
